// File: rtl/core/mtf_pkg.sv
// Package for the move-to-front coder: payload types, wave and commit structs.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

   localparam int SYMBOL_WIDTH       = 8;
   localparam int ALPHABET_SIZE_DFLT = 256;

   typedef logic [SYMBOL_WIDTH-1:0] symbol_type;

   typedef struct packed {
      symbol_type value;
      logic       last_of_block;
   } req_type;

   typedef struct packed {
      symbol_type coded;
      logic       block_end;
   } rsp_type;

   // One item walking along the cell chain.
   typedef struct packed {
      logic       valid;
      logic       active;    // value inside the alphabet
      logic       found;
      logic       mode;      // 1: decode
      logic       last;
      symbol_type key;
      symbol_type carry;     // entry displaced by the previous cell
      symbol_type result;
   } wave_type;

   // Broadcast from the tail of the chain when an item retires.
   typedef struct packed {
      logic       restore;   // back to identity order
      logic       front_wr;  // write symbol into the front cell
      symbol_type symbol;
   } commit_type;

endpackage

`default_nettype wire

// File: rtl/core/mtf_cell.sv
// One entry of the recency list plus its stage of the item wave.
`timescale 1ns / 1ps
`default_nettype none

module mtf_cell #(
   parameter int INDEX = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 hold,
   input  mtf_pkg::commit_type commit,
   input  mtf_pkg::wave_type   wave_in,
   output mtf_pkg::wave_type   wave_out
);

   localparam mtf_pkg::symbol_type CELL_ID = mtf_pkg::symbol_type'(INDEX);
   localparam bit                  IS_FRONT = (INDEX == 0);

   mtf_pkg::symbol_type entry_ff, entry_in;
   mtf_pkg::wave_type   stage_ff, stage_in;
   logic                work;
   logic                match;

   assign work  = wave_in.valid && wave_in.active && !wave_in.found;
   assign match = wave_in.mode ? (wave_in.key == CELL_ID) : (entry_ff == wave_in.key);

   always_comb begin
      entry_in = entry_ff;
      stage_in = wave_in;
      if (commit.restore) begin
         entry_in = CELL_ID;
      end else if (commit.front_wr && IS_FRONT) begin
         entry_in = commit.symbol;
      end else if (work) begin
         // front cell is rewritten at retire time
         if (!IS_FRONT) begin
            entry_in = wave_in.carry;
         end
         if (match) begin
            stage_in.found  = 1'b1;
            stage_in.result = wave_in.mode ? entry_ff : CELL_ID;
         end else begin
            stage_in.carry = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= CELL_ID;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (!hold) begin
         stage_ff <= stage_in;
      end
   end

   assign wave_out = stage_ff;

endmodule

`default_nettype wire

// File: rtl/core/move_to_front_coder.sv
// Move-to-front coder: encodes bytes to ranks or decodes ranks to bytes.
//
// Input channel req_valid/req_ready/req_data carries one item (value,
// last_of_block); result channel rsp_valid/rsp_ready/rsp_data returns one
// item (coded, block_end) per input, in order. csr_valid/csr_ready/csr_data
// writes decode_mode (0 encode, 1 decode); write it only while idle.
// The list lives in a chain of ALPHABET_SIZE cells; an item walks the chain
// one cell per cycle, shifting entries back behind it, and at the tail
// writes the symbol into the front cell (and restores identity order after
// a last_of_block item). One item is in flight at a time: a new item is
// taken only after the previous one has walked the cell chain and retired,
// as req_ready returns in the cycle after the item retires.
// A finished result sits in the output register; the next item may start
// while it waits. If the receiver stalls, the next item holds at the tail
// of the chain until the output register frees up.
// Reset (synchronous) sets the list to identity order and decode_mode to 0.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_coder #(
   parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DFLT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  mtf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output mtf_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire               csr_data
);

   localparam int CMP_WIDTH = mtf_pkg::SYMBOL_WIDTH + 1;

   mtf_pkg::wave_type   wave_chain [0:ALPHABET_SIZE];
   mtf_pkg::wave_type   wave0_ff, wave0_in;
   mtf_pkg::wave_type   tail;
   mtf_pkg::commit_type commit;
   mtf_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff;
   logic                busy_ff;
   logic                mode_ff;
   logic                accept;
   logic                hold;
   logic                retire;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (retire) begin
         busy_ff <= 1'b0;
      end
   end

   always_comb begin
      wave0_in       = wave0_ff;
      wave0_in.valid = accept;
      if (accept) begin
         wave0_in.active = {1'b0, req_data.value} < CMP_WIDTH'(ALPHABET_SIZE);
         wave0_in.found  = 1'b0;
         wave0_in.mode   = mode_ff;
         wave0_in.last   = req_data.last_of_block;
         wave0_in.key    = req_data.value;
         wave0_in.carry  = req_data.value;
         wave0_in.result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave0_ff <= '0;
      end else begin
         wave0_ff <= wave0_in;
      end
   end

   assign wave_chain[0] = wave0_ff;

   genvar k;
   generate
      for (k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
         mtf_cell #(
            .INDEX (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .hold     (hold),
            .commit   (commit),
            .wave_in  (wave_chain[k]),
            .wave_out (wave_chain[k+1])
         );
      end
   endgenerate

   assign tail   = wave_chain[ALPHABET_SIZE];
   assign hold   = tail.valid && rsp_valid_ff && !rsp_ready;
   assign retire = tail.valid && !hold;

   always_comb begin
      commit.restore  = retire && tail.last;
      commit.front_wr = retire && tail.found;
      commit.symbol   = tail.mode ? tail.result : tail.key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (retire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_data_ff.coded     <= tail.found ? tail.result : '0;
         rsp_data_ff.block_end <= tail.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/move_to_front_coder_test.sv
// Self-checking testbench for the move-to-front coder: directed table plus random blocks.
`timescale 1ns / 1ps

module move_to_front_coder_test;

   localparam int ALPHABET   = mtf_pkg::ALPHABET_SIZE_DFLT;
   localparam int IDLE_PCT   = 17;
   localparam int PHASES     = 8;
   localparam int PHASE_LEN  = 200;
   localparam int ROW_COUNT  = 17;
   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   typedef struct packed {
      logic                mode;
      mtf_pkg::symbol_type value;
      logic                last;
      logic                typed;    // golden below is the expected code
      mtf_pkg::symbol_type golden;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mtf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mtf_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_data = 1'b0;

   // predictor state
   mtf_pkg::symbol_type recency_model [ALPHABET];
   logic                decode_on;
   mtf_pkg::rsp_type    pending_codes [$];
   int                  mismatch_count = 0;
   bit                  quiet = 1'b0;
   directed_row_type    directed_rows [ROW_COUNT];

   move_to_front_coder #(
      .ALPHABET_SIZE(ALPHABET)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void list_to_identity();
      for (int i = 0; i < ALPHABET; i++) recency_model[i] = mtf_pkg::symbol_type'(i);
   endfunction

   function automatic mtf_pkg::rsp_type mtf_apply(input mtf_pkg::req_type item);
      mtf_pkg::rsp_type    result;
      int                  rank;
      mtf_pkg::symbol_type sym;
      result.coded     = '0;
      result.block_end = item.last_of_block;
      rank = -1;
      if (int'(item.value) < ALPHABET) begin
         if (decode_on) rank = int'(item.value);
         else begin
            for (int j = 0; j < ALPHABET; j++)
               if (rank < 0 && recency_model[j] == item.value) rank = j;
         end
      end
      if (rank >= 0) begin
         sym = recency_model[rank];
         result.coded = decode_on ? sym : mtf_pkg::symbol_type'(rank);
         for (int k = rank; k > 0; k--) recency_model[k] = recency_model[k-1];
         recency_model[0] = sym;
      end
      if (item.last_of_block) list_to_identity();
      return result;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input mtf_pkg::req_type item, input logic typed,
                            input mtf_pkg::symbol_type golden);
      mtf_pkg::rsp_type predicted;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = mtf_apply(item);
      if (typed) predicted.coded = golden;
      pending_codes.push_back(predicted);
      @(negedge clock);
   endtask

   // Mode changes only once the coder has drained.
   task automatic write_mode(input logic mode);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      decode_on = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      mtf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $display("%0t: unexpected item coded %0d block_end %0d", $time,
                     rsp_data.coded, rsp_data.block_end);
            mismatch_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_data.coded !== want.coded) begin
               $display("%0t: coded expected %0d got %0d", $time, want.coded, rsp_data.coded);
               mismatch_count++;
            end
            if (rsp_data.block_end !== want.block_end) begin
               $display("%0t: block_end expected %0d got %0d", $time,
                        want.block_end, rsp_data.block_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      mtf_pkg::req_type    item;
      int                  r;
      mtf_pkg::symbol_type base;
      logic                mode;

      // mode, value, last, typed, golden
      directed_rows[0]  = '{MODE_ENC, 8'd0,   1'b0, 1'b1, 8'd0};
      directed_rows[1]  = '{MODE_ENC, 8'd255, 1'b0, 1'b1, 8'd255};
      directed_rows[2]  = '{MODE_ENC, 8'd255, 1'b0, 1'b1, 8'd0};
      directed_rows[3]  = '{MODE_ENC, 8'd0,   1'b0, 1'b1, 8'd1};
      directed_rows[4]  = '{MODE_ENC, 8'd128, 1'b1, 1'b0, 8'd0};
      directed_rows[5]  = '{MODE_ENC, 8'd7,   1'b1, 1'b1, 8'd7};
      directed_rows[6]  = '{MODE_DEC, 8'd0,   1'b0, 1'b1, 8'd0};
      directed_rows[7]  = '{MODE_DEC, 8'd255, 1'b0, 1'b1, 8'd255};
      directed_rows[8]  = '{MODE_DEC, 8'd0,   1'b0, 1'b1, 8'd255};
      directed_rows[9]  = '{MODE_DEC, 8'd1,   1'b0, 1'b1, 8'd0};
      directed_rows[10] = '{MODE_DEC, 8'd255, 1'b1, 1'b0, 8'd0};
      directed_rows[11] = '{MODE_DEC, 8'd255, 1'b0, 1'b1, 8'd255};
      // mode flips in the middle of a block: list must carry over
      directed_rows[12] = '{MODE_ENC, 8'd255, 1'b0, 1'b0, 8'd0};
      directed_rows[13] = '{MODE_ENC, 8'd170, 1'b0, 1'b0, 8'd0};
      directed_rows[14] = '{MODE_DEC, 8'd85,  1'b0, 1'b0, 8'd0};
      directed_rows[15] = '{MODE_DEC, 8'd170, 1'b1, 1'b0, 8'd0};
      directed_rows[16] = '{MODE_ENC, 8'd85,  1'b1, 1'b0, 8'd0};

      list_to_identity();
      decode_on = MODE_ENC;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != decode_on) write_mode(directed_rows[i].mode);
         item.value         = directed_rows[i].value;
         item.last_of_block = directed_rows[i].last;
         send_item(item, directed_rows[i].typed, directed_rows[i].golden);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         mode = phase[0];
         write_mode(mode);
         quiet = (phase == 3);
         base  = mtf_pkg::symbol_type'($urandom_range(255));
         for (int n = 0; n < PHASE_LEN; n++) begin
            r = $urandom_range(99);
            // nearly half from a small working set so ranks stay low and the list churns
            if (r < 45) item.value = (decode_on ? 8'd0 : base)
                                     + mtf_pkg::symbol_type'($urandom_range(5));
            else if (r < 55) item.value = r[0] ? 8'hFF : 8'h00;
            else item.value = mtf_pkg::symbol_type'($urandom_range(255));
            item.last_of_block = ($urandom_range(99) < 3);
            send_item(item, 1'b0, 8'd0);
         end
         quiet = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (ALPHABET + 8) @(negedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
